@@ sv/bmsp_pkg.sv @@
// bmsp_pkg: types, message codes and decode helpers for the ble-midi stream parser
// used by every module of the block; depends on nothing
package bmsp_pkg;

  localparam logic [3:0] MT_OFF     = 4'd0;
  localparam logic [3:0] MT_ON      = 4'd1;
  localparam logic [3:0] MT_SYSEX   = 4'd7;
  localparam logic [3:0] MT_COMMON  = 4'd8;
  localparam logic [3:0] MT_RT      = 4'd9;
  localparam logic [3:0] MT_UNKNOWN = 4'd10;

  localparam logic [7:0] ST_CHAN  = 8'h80;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_MTC   = 8'hF1;
  localparam logic [7:0] ST_SPP   = 8'hF2;
  localparam logic [7:0] ST_SONG  = 8'hF3;
  localparam logic [7:0] ST_TUNE  = 8'hF6;
  localparam logic [7:0] ST_EOX   = 8'hF7;
  localparam logic [7:0] ST_RT    = 8'hF8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic       last_of_packet;
  } bmsp_in_t;

  typedef struct packed {
    logic [3:0] msg_type;
    logic [5:0] msg_length;
    logic [4:0] byte_index;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic       last_of_run;
  } bmsp_out_t;

  typedef struct packed {
    logic [3:0] msg_type;
    logic [5:0] msg_length;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
  } msg_t;

  typedef struct packed {
    logic       has_dump;
    logic       bank;
    logic [5:0] dump_len;
    logic       has_msg;
    msg_t       msg;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [4:0] addr;
    logic [7:0] data;
  } wr_t;

  typedef enum logic [1:0] {BK_IDLE, BK_DUMP, BK_MSG} bk_state_t;

  function automatic logic [1:0] chan_need(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s[7:4] == 4'hC || s[7:4] == 4'hD) n = 2'd1;
    else if (s[7:4] >= 4'h8 && s[7:4] <= 4'hE) n = 2'd2;
    return n;
  endfunction

  function automatic logic [1:0] common_need(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s == ST_MTC || s == ST_SONG) n = 2'd1;
    else if (s == ST_SPP) n = 2'd2;
    return n;
  endfunction

  function automatic msg_t part_msg(input logic [7:0] s, input logic [1:0] cnt,
                                    input logic [7:0] d0, input logic [7:0] d1);
    msg_t m;
    m.msg_type = MT_UNKNOWN;
    if (s >= ST_RT) m.msg_type = MT_RT;
    else if (s >= ST_MTC && s <= ST_TUNE) m.msg_type = MT_COMMON;
    else if (s >= ST_CHAN && s < ST_SYSEX) m.msg_type = {1'b0, s[6:4]};
    if (m.msg_type == MT_ON && cnt >= 2'd2 && d1 == 8'd0) m.msg_type = MT_OFF;
    m.msg_length = {4'd0, cnt} + 6'd1;
    m.byte_a = s;
    m.byte_b = (cnt >= 2'd1) ? d0 : 8'd0;
    m.byte_c = (cnt >= 2'd2) ? d1 : 8'd0;
    return m;
  endfunction

endpackage

@@ sv/bmsp_front.sv @@
// bmsp_front: per-byte packet parse, running status and sysex collection
// depends on bmsp_pkg; issues commands to the queue and writes the sysex store
module bmsp_front import bmsp_pkg::*; #(
  parameter int SYSEX_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bmsp_in_t in_data,
  input  logic     q_space,
  input  logic     dump_pend,
  output logic     cmd_push,
  output cmd_t     cmd,
  output wr_t      wr
);

  logic       mal_r, mal_nxt;
  logic       exp_ts_r, exp_ts_nxt;
  logic       scan_r, scan_nxt;
  logic       pend_r, pend_nxt;
  logic       open_r, open_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       bank_r, bank_nxt;
  logic [7:0] run_r, run_nxt;
  logic [7:0] pst_r, pst_nxt;
  logic [7:0] pd0_r, pd0_nxt;
  logic [7:0] pd1_r, pd1_nxt;
  logic [1:0] pcnt_r, pcnt_nxt;
  logic [1:0] pneed_r, pneed_nxt;
  logic       accept;

  assign in_ready = q_space && !dump_pend;
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept && (cmd.has_dump || cmd.has_msg);

  always_comb begin
    logic [7:0] b;
    logic       do_main;
    b = in_data.data_byte;
    do_main = 1'b0;
    mal_nxt = mal_r; exp_ts_nxt = exp_ts_r; scan_nxt = scan_r; pend_nxt = pend_r;
    open_nxt = open_r; cnt_nxt = cnt_r; bank_nxt = bank_r; run_nxt = run_r;
    pst_nxt = pst_r; pd0_nxt = pd0_r; pd1_nxt = pd1_r; pcnt_nxt = pcnt_r;
    pneed_nxt = pneed_r;
    cmd = '0;
    wr = '0;
    if (in_data.first_of_packet) begin
      exp_ts_nxt = 1'b1;
      scan_nxt = 1'b0;
      pend_nxt = 1'b0;
      mal_nxt = !b[7] || in_data.last_of_packet;
      if (mal_nxt) begin
        cmd.has_msg = 1'b1;
        cmd.msg = '{MT_UNKNOWN, 6'd1, b, 8'd0, 8'd0};
      end
    end else if (mal_r) begin
      cmd.has_msg = 1'b1;
      cmd.msg = '{MT_UNKNOWN, 6'd1, b, 8'd0, 8'd0};
    end else if (scan_r) begin
      if (!pend_r) begin
        if (!b[7]) begin
          if (cnt_nxt < 6'(SYSEX_DEPTH)) begin
            wr = '{1'b1, bank_nxt, cnt_nxt[4:0], b};
            cnt_nxt = cnt_nxt + 6'd1;
          end
        end else if (in_data.last_of_packet) begin
          scan_nxt = 1'b0;
        end else begin
          pend_nxt = 1'b1;
        end
      end else begin
        pend_nxt = 1'b0;
        if (b == ST_EOX) begin
          if (cnt_nxt < 6'(SYSEX_DEPTH)) begin
            wr = '{1'b1, bank_nxt, cnt_nxt[4:0], ST_EOX};
            cnt_nxt = cnt_nxt + 6'd1;
          end
          scan_nxt = 1'b0;
          exp_ts_nxt = 1'b1;
          cmd.has_dump = 1'b1;
          cmd.bank = bank_nxt;
          cmd.dump_len = cnt_nxt;
          bank_nxt = ~bank_nxt;
          open_nxt = 1'b0;
          cnt_nxt = 6'd0;
          run_nxt = 8'd0;
        end else if (b >= ST_RT) begin
          cmd.has_msg = 1'b1;
          cmd.msg = '{MT_RT, 6'd1, b, 8'd0, 8'd0};
        end else begin
          cmd.has_dump = 1'b1;
          cmd.bank = bank_nxt;
          cmd.dump_len = cnt_nxt;
          bank_nxt = ~bank_nxt;
          open_nxt = 1'b0;
          cnt_nxt = 6'd0;
          run_nxt = 8'd0;
          scan_nxt = 1'b0;
          exp_ts_nxt = 1'b0;
          do_main = 1'b1;
        end
      end
    end else begin
      do_main = 1'b1;
    end

    if (do_main) begin
      if (exp_ts_nxt && b[7]) begin
        exp_ts_nxt = 1'b0;
      end else if (exp_ts_nxt && open_nxt) begin
        if (cnt_nxt < 6'(SYSEX_DEPTH)) begin
          wr = '{1'b1, bank_nxt, cnt_nxt[4:0], b};
          cnt_nxt = cnt_nxt + 6'd1;
        end
      end else begin
        exp_ts_nxt = 1'b0;
        if (!b[7]) begin
          if (pst_nxt == 8'd0 && run_nxt == 8'd0) begin
            cmd.has_msg = 1'b1;
            cmd.msg = '{MT_UNKNOWN, 6'd1, b, 8'd0, 8'd0};
          end else begin
            if (pst_nxt == 8'd0) begin
              pst_nxt = run_nxt;
              pcnt_nxt = 2'd0;
              pneed_nxt = chan_need(run_nxt);
            end
            if (pcnt_nxt == 2'd0) begin
              pd0_nxt = b;
              pcnt_nxt = 2'd1;
            end else if (pcnt_nxt == 2'd1) begin
              pd1_nxt = b;
              pcnt_nxt = 2'd2;
            end
            if (pcnt_nxt >= pneed_nxt) begin
              cmd.has_msg = 1'b1;
              cmd.msg = part_msg(pst_nxt, pcnt_nxt, pd0_nxt, pd1_nxt);
              run_nxt = (pst_nxt >= ST_SYSEX) ? 8'd0 : pst_nxt;
              pst_nxt = 8'd0;
              pcnt_nxt = 2'd0;
              pneed_nxt = 2'd0;
              exp_ts_nxt = 1'b1;
            end
          end
        end else if (b == ST_SYSEX) begin
          open_nxt = 1'b1;
          wr = '{1'b1, bank_nxt, 5'd0, ST_SYSEX};
          cnt_nxt = 6'd1;
          scan_nxt = 1'b1;
          pend_nxt = 1'b0;
          exp_ts_nxt = 1'b1;
        end else begin
          exp_ts_nxt = 1'b1;
          if (b == ST_EOX) begin
            if (open_nxt) begin
              if (cnt_nxt < 6'(SYSEX_DEPTH)) begin
                wr = '{1'b1, bank_nxt, cnt_nxt[4:0], ST_EOX};
                cnt_nxt = cnt_nxt + 6'd1;
              end
              cmd.has_dump = 1'b1;
              cmd.bank = bank_nxt;
              cmd.dump_len = cnt_nxt;
              bank_nxt = ~bank_nxt;
              open_nxt = 1'b0;
              cnt_nxt = 6'd0;
              run_nxt = 8'd0;
            end else begin
              cmd.has_msg = 1'b1;
              cmd.msg = '{MT_UNKNOWN, 6'd1, b, 8'd0, 8'd0};
            end
          end else if (b >= ST_RT) begin
            cmd.has_msg = 1'b1;
            cmd.msg = '{MT_RT, 6'd1, b, 8'd0, 8'd0};
          end else begin
            pst_nxt = b;
            pcnt_nxt = 2'd0;
            pneed_nxt = (b >= ST_MTC && b <= ST_TUNE) ? common_need(b) : chan_need(b);
            if (pneed_nxt == 2'd0) begin
              cmd.has_msg = 1'b1;
              cmd.msg = part_msg(pst_nxt, 2'd0, pd0_nxt, pd1_nxt);
              run_nxt = (pst_nxt >= ST_SYSEX) ? 8'd0 : pst_nxt;
              pst_nxt = 8'd0;
              pneed_nxt = 2'd0;
            end else begin
              exp_ts_nxt = 1'b0;
            end
          end
        end
      end
    end
    if (!accept) wr.en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mal_r <= 1'b0; exp_ts_r <= 1'b1; scan_r <= 1'b0; pend_r <= 1'b0;
      open_r <= 1'b0; cnt_r <= 6'd0; bank_r <= 1'b0; run_r <= 8'd0;
      pst_r <= 8'd0; pd0_r <= 8'd0; pd1_r <= 8'd0; pcnt_r <= 2'd0; pneed_r <= 2'd0;
    end else if (accept) begin
      mal_r <= mal_nxt; exp_ts_r <= exp_ts_nxt; scan_r <= scan_nxt; pend_r <= pend_nxt;
      open_r <= open_nxt; cnt_r <= cnt_nxt; bank_r <= bank_nxt; run_r <= run_nxt;
      pst_r <= pst_nxt; pd0_r <= pd0_nxt; pd1_r <= pd1_nxt; pcnt_r <= pcnt_nxt;
      pneed_r <= pneed_nxt;
    end
  end

endmodule

@@ sv/bmsp_queue.sv @@
// bmsp_queue: two-entry command queue between parse front and result back
// depends on bmsp_pkg for the command type
module bmsp_queue import bmsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic space,
  input  logic pop,
  output cmd_t head,
  output logic head_valid,
  output logic dump_queued
);

  cmd_t       ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign space       = cnt_r != 2'd2;
  assign head_valid  = cnt_r != 2'd0;
  assign head        = ent_r[rptr_r];
  assign dump_queued = (head_valid && ent_r[rptr_r].has_dump) ||
                       (cnt_r == 2'd2 && ent_r[~rptr_r].has_dump);

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ sv/bmsp_back.sv @@
// bmsp_back: executes queued commands, reads the sysex store, drives results
// depends on bmsp_pkg; holds the two-bank sysex store
module bmsp_back import bmsp_pkg::*; #(
  parameter int SYSEX_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  wr_t       wr,
  input  cmd_t      head,
  input  logic      head_valid,
  output logic      pop,
  output logic      dump_busy,
  output logic      out_valid,
  input  logic      out_ready,
  output bmsp_out_t out_data
);

  localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;

  logic [7:0] mem [2][SYSEX_DEPTH];
  bk_state_t  st_r, st_nxt;
  cmd_t       cmd_r;
  logic [5:0] idx_r, idx_nxt;
  logic       can_ld, ld, ld_sx, last, rd_bank;
  logic [5:0] rd_idx;
  cmd_t       lcmd;
  logic       ov_r, sel_r, olast_r;
  msg_t       omsg_r;
  logic [5:0] olen_r, oidx_r;
  logic [7:0] sx_byte_r;

  assign can_ld    = !ov_r || out_ready;
  assign dump_busy = st_r == BK_DUMP;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (head_valid && can_ld && head.has_dump) begin
          if (head.dump_len > 6'd1) st_nxt = BK_DUMP;
          else if (head.has_msg) st_nxt = BK_MSG;
        end
      end
      BK_DUMP: begin
        if (can_ld && idx_r + 6'd1 == cmd_r.dump_len)
          st_nxt = cmd_r.has_msg ? BK_MSG : BK_IDLE;
      end
      BK_MSG: begin
        if (can_ld) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0; ld = 1'b0; ld_sx = 1'b0; last = 1'b0;
    rd_bank = cmd_r.bank; rd_idx = idx_r; idx_nxt = idx_r; lcmd = cmd_r;
    unique case (st_r)
      BK_IDLE: begin
        if (head_valid && can_ld) begin
          pop = 1'b1;
          ld = 1'b1;
          lcmd = head;
          if (head.has_dump) begin
            ld_sx = 1'b1;
            rd_bank = head.bank;
            rd_idx = 6'd0;
            idx_nxt = 6'd1;
            last = head.dump_len == 6'd1 && !head.has_msg;
          end else begin
            last = 1'b1;
          end
        end
      end
      BK_DUMP: begin
        if (can_ld) begin
          ld = 1'b1;
          ld_sx = 1'b1;
          idx_nxt = idx_r + 6'd1;
          last = idx_r + 6'd1 == cmd_r.dump_len && !cmd_r.has_msg;
        end
      end
      BK_MSG: begin
        if (can_ld) begin
          ld = 1'b1;
          last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.bank][wr.addr[AW-1:0]] <= wr.data;
    if (ld && ld_sx) sx_byte_r <= mem[rd_bank][rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= head;
    idx_r <= idx_nxt;
    if (ld) begin
      sel_r   <= ld_sx;
      omsg_r  <= lcmd.msg;
      olen_r  <= lcmd.dump_len;
      oidx_r  <= rd_idx;
      olast_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ld) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
  always_comb begin
    if (sel_r) begin
      out_data = '{MT_SYSEX, olen_r, oidx_r[4:0], sx_byte_r, 8'd0, 8'd0, olast_r};
    end else begin
      out_data = '{omsg_r.msg_type, omsg_r.msg_length, 5'd0, omsg_r.byte_a,
                   omsg_r.byte_b, omsg_r.byte_c, olast_r};
    end
  end

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_DUMP |-> idx_r < cmd_r.dump_len) else $error("dump index past length");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");
  a_sx_index: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && sel_r |-> oidx_r < olen_r) else $error("sysex index beyond length");
  a_dump_len: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.has_dump |-> head.dump_len != 6'd0 && head.dump_len <= 6'(SYSEX_DEPTH))
    else $error("bad sysex dump length");

endmodule

@@ sv/ble_midi_stream_parser.sv @@
// ble_midi_stream_parser: top level of the ble-midi packet byte parser
// depends on bmsp_pkg, bmsp_front, bmsp_queue and bmsp_back
//
// in channel: one packet byte per request with first/last packet marks.
// out channel: decoded messages; one request per short, real-time or
// unknown message, a run of requests per completed sysex (one per stored
// byte, byte_index counting up), last_of_run set on the final result that
// one input byte causes.
// throughput: one input byte per cycle while no sysex readout is pending;
// a sysex readout passes each stored byte through the back end's store
// read port, and input is held off until it has been handed over.
// a result is registered in the command queue, then in the output register.
// a two-entry command queue sits between the parse front and the result
// back end, and the output register lets input be taken while a result
// waits; when the receiver stalls, the queue fills and in_ready drops.
// reset clears all parse state, the queue and the output register; the
// sysex store needs no clearing, only written entries are ever read.
module ble_midi_stream_parser import bmsp_pkg::*; #(
  parameter int SYSEX_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bmsp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bmsp_out_t out_data
);

  logic cmd_push, q_space, pop, head_valid, dump_queued, dump_busy;
  cmd_t cmd, head;
  wr_t  wr;

  bmsp_front #(.SYSEX_DEPTH(SYSEX_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_space, .dump_pend(dump_queued || dump_busy),
    .cmd_push, .cmd, .wr
  );

  bmsp_queue u_queue (
    .clk, .rst_n, .push(cmd_push), .push_cmd(cmd), .space(q_space),
    .pop, .head, .head_valid, .dump_queued
  );

  bmsp_back #(.SYSEX_DEPTH(SYSEX_DEPTH)) u_back (
    .clk, .rst_n, .wr, .head, .head_valid, .pop, .dump_busy,
    .out_valid, .out_ready, .out_data
  );

endmodule
